>>> sv/pcet_pkg.sv
// ----------------------------------------------------------------------------
// pcet_pkg
// shared types, op codes and sizes of the extremum tracker
// ----------------------------------------------------------------------------
package pcet_pkg;

   localparam int PCET_MAX_CLASSES = 31;
   localparam int PCET_QUANTITIES  = 4;
   localparam int PCET_AXES        = 3;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   typedef logic [2:0][31:0] axis_vec_type;

   typedef struct packed {
      logic [62:0]      mag;
      logic [2:0][30:0] peak;
      logic [2:0][31:0] trough;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

>>> sv/pcet_merge.sv
// ----------------------------------------------------------------------------
// pcet_merge
// folds one sample into a stored entry: raises peaks, lowers troughs
// ----------------------------------------------------------------------------
module pcet_merge (
   input  pcet_pkg::entry_type    cur,
   input  logic [62:0]            mag,
   input  pcet_pkg::axis_vec_type axis,
   output pcet_pkg::entry_type    upd
);
   import pcet_pkg::*;

   always_comb begin
      upd = cur;
      if (mag > cur.mag) begin
         upd.mag = mag;
      end
      for (int a = 0; a < PCET_AXES; a++) begin
         if (!axis[a][31] && (axis[a][30:0] > cur.peak[a])) begin
            upd.peak[a] = axis[a][30:0];
         end
         if ($signed(axis[a]) < $signed(cur.trough[a])) begin
            upd.trough[a] = axis[a];
         end
      end
   end

endmodule

>>> sv/pcet_store.sv
// ----------------------------------------------------------------------------
// pcet_store
// entry memory, one write and one registered read a cycle, write forwarding
// ----------------------------------------------------------------------------
module pcet_store #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  pcet_pkg::entry_type wr_data,
   output pcet_pkg::entry_type rd_data
);
   import pcet_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;
   entry_type fwd_data_ff;
   logic      fwd_ff;
   logic      fwd_in;

   assign fwd_in  = rd_en && wr_en && (rd_addr == wr_addr);
   assign rd_data = fwd_ff ? fwd_data_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      fwd_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= fwd_in;
      end
   end

endmodule

>>> sv/per_class_extremum_tracker_unit.sv
// ----------------------------------------------------------------------------
// per_class_extremum_tracker_unit
// running peaks and troughs per particle class and quantity in one entry memory
//
//   channel  direction  words
//   req_     in         sample, read or clear command
//   rsp_     out        seven values of one row and quantity, one per read
//
// a sample writes the store once per row, row 0 then the class row if in range
// a read goes through a store read, then the output register
// a clear and the pass after reset zero the store one entry a cycle:
// (MAX_CLASSES+1)*QUANTITIES entries, 128 by default, with req_stall high
// reset is synchronous; a waiting result holds only reads back, samples go on
// ----------------------------------------------------------------------------
module per_class_extremum_tracker_unit #(
   parameter int MAX_CLASSES = pcet_pkg::PCET_MAX_CLASSES,
   parameter int QUANTITIES  = pcet_pkg::PCET_QUANTITIES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [4:0]         req_particle_class,
   input  logic [1:0]         req_quantity,
   input  logic [62:0]        req_magnitude_squared,
   input  logic signed [31:0] req_axis_x,
   input  logic signed [31:0] req_axis_y,
   input  logic signed [31:0] req_axis_z,
   input  logic [4:0]         req_read_row,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [62:0]        rsp_peak_magnitude_squared,
   output logic [30:0]        rsp_peak_x,
   output logic [30:0]        rsp_peak_y,
   output logic [30:0]        rsp_peak_z,
   output logic signed [31:0] rsp_trough_x,
   output logic signed [31:0] rsp_trough_y,
   output logic signed [31:0] rsp_trough_z
);
   import pcet_pkg::*;

   localparam int ROWS  = MAX_CLASSES + 1;
   localparam int DEPTH = ROWS * QUANTITIES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_ROW0  = 3'd2;
   localparam logic [2:0] ST_ROWC  = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;

   function automatic logic [AW-1:0] entry_addr(input logic [8:0] row,
                                                 input logic [1:0] qty);
      logic [11:0] full;
      full = 12'(row) * 12'(QUANTITIES) + 12'(qty);
      return full[AW-1:0];
   endfunction

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0] addr_a_ff, addr_b_ff;
   logic          class_ok_ff;
   logic          zero_ff;
   logic [62:0]   mag_ff;
   axis_vec_type  axis_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   entry_type     rsp_ff;

   logic          slot_open;
   logic          accept;
   logic          q_ok, class_ok, row_ok;
   logic [AW-1:0] addr_a, addr_b, addr_r;

   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   entry_type     wr_data, rd_data, merged;

   assign q_ok     = int'(req_quantity) < QUANTITIES;
   assign class_ok = int'(req_particle_class) < MAX_CLASSES;
   assign row_ok   = int'(req_read_row) <= MAX_CLASSES;
   assign addr_a   = entry_addr(9'd0, req_quantity);
   assign addr_b   = entry_addr(9'(req_particle_class) + 9'd1, req_quantity);
   assign addr_r   = entry_addr(9'(req_read_row), req_quantity);

   assign slot_open = (state_ff == ST_IDLE) || (state_ff == ST_ROWC);
   assign req_stall = !slot_open ||
                      ((req_op == OP_READ) && rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   pcet_merge u_merge (
      .cur  (rd_data),
      .mag  (mag_ff),
      .axis (axis_ff),
      .upd  (merged)
   );

   pcet_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // store access
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = addr_a;
      wr_en   = 1'b0;
      wr_addr = addr_a_ff;
      wr_data = merged;
      if (accept && q_ok && (req_op == OP_SAMPLE)) begin
         rd_en   = 1'b1;
         rd_addr = addr_a;
      end else if (accept && q_ok && row_ok && (req_op == OP_READ)) begin
         rd_en   = 1'b1;
         rd_addr = addr_r;
      end else if ((state_ff == ST_ROW0) && class_ok_ff) begin
         rd_en   = 1'b1;
         rd_addr = addr_b_ff;
      end
      case (state_ff)
         ST_ROW0: begin
            wr_en   = 1'b1;
            wr_addr = addr_a_ff;
         end
         ST_ROWC: begin
            wr_en   = 1'b1;
            wr_addr = addr_b_ff;
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_ff;
            wr_data = '0;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // sequencing
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         ST_ROW0: begin
            state_in = class_ok_ff ? ST_ROWC : ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (accept) begin
         case (req_op)
            OP_SAMPLE: state_in = q_ok ? ST_ROW0 : ST_IDLE;
            OP_READ:   state_in = ST_READ;
            OP_CLEAR: begin
               state_in   = ST_CLEAR;
               clr_cnt_in = '0;
            end
            default:   state_in = ST_IDLE;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_READ) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         addr_a_ff   <= addr_a;
         addr_b_ff   <= addr_b;
         class_ok_ff <= class_ok;
         zero_ff     <= !(q_ok && row_ok);
         mag_ff      <= req_magnitude_squared;
         axis_ff     <= {req_axis_z, req_axis_y, req_axis_x};
      end
      if (state_ff == ST_READ) begin
         rsp_ff <= zero_ff ? '0 : rd_data;
      end
   end

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_peak_magnitude_squared = rsp_ff.mag;
   assign rsp_peak_x                 = rsp_ff.peak[0];
   assign rsp_peak_y                 = rsp_ff.peak[1];
   assign rsp_peak_z                 = rsp_ff.peak[2];
   assign rsp_trough_x               = rsp_ff.trough[0];
   assign rsp_trough_y               = rsp_ff.trough[1];
   assign rsp_trough_z               = rsp_ff.trough[2];

endmodule

>>> tb/extremum_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// extremum_checker
// watches both channels of the extremum tracker, keeps its own copy of the
// peak and trough store, predicts every read word and compares it field by
// field with what the block returns, in order
// ----------------------------------------------------------------------------
module extremum_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [4:0]         req_particle_class,
   input  logic [1:0]         req_quantity,
   input  logic [62:0]        req_magnitude_squared,
   input  logic signed [31:0] req_axis_x,
   input  logic signed [31:0] req_axis_y,
   input  logic signed [31:0] req_axis_z,
   input  logic [4:0]         req_read_row,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [62:0]        rsp_peak_magnitude_squared,
   input  logic [30:0]        rsp_peak_x,
   input  logic [30:0]        rsp_peak_y,
   input  logic [30:0]        rsp_peak_z,
   input  logic signed [31:0] rsp_trough_x,
   input  logic signed [31:0] rsp_trough_y,
   input  logic signed [31:0] rsp_trough_z,
   output int                 error_count,
   output int                 outstanding
);
   import pcet_pkg::*;

   localparam int ROWS = PCET_MAX_CLASSES + 1;

   entry_type extremum_store [ROWS * PCET_QUANTITIES];
   entry_type expected_rows [$];

   function automatic entry_type raise_entry(entry_type old_entry, logic [62:0] mag,
                                             axis_vec_type ax);
      entry_type e;
      int        a;
      e = old_entry;
      if (mag > e.mag) e.mag = mag;
      for (a = 0; a < PCET_AXES; a++) begin
         if ($signed(ax[a]) > $signed({1'b0, e.peak[a]})) e.peak[a] = ax[a][30:0];
         if ($signed(ax[a]) < $signed(e.trough[a])) e.trough[a] = ax[a];
      end
      return e;
   endfunction

   task automatic check_value(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, what, want, got);
         error_count++;
      end
   endtask

   task automatic clear_store();
      foreach (extremum_store[i]) extremum_store[i] = '0;
   endtask

   always @(posedge clock) begin
      entry_type    want;
      axis_vec_type ax;
      int           slot;
      if (reset) begin
         clear_store();
         expected_rows.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rows.size() == 0) begin
               $display("%0t: unexpected word, expected none got mag %h", $time,
                        rsp_peak_magnitude_squared);
               error_count++;
            end else begin
               want = expected_rows.pop_front();
               check_value("peak_magnitude_squared", {1'b0, want.mag},
                           {1'b0, rsp_peak_magnitude_squared});
               check_value("peak_x", {33'd0, want.peak[0]}, {33'd0, rsp_peak_x});
               check_value("peak_y", {33'd0, want.peak[1]}, {33'd0, rsp_peak_y});
               check_value("peak_z", {33'd0, want.peak[2]}, {33'd0, rsp_peak_z});
               check_value("trough_x", {32'd0, want.trough[0]}, {32'd0, rsp_trough_x});
               check_value("trough_y", {32'd0, want.trough[1]}, {32'd0, rsp_trough_y});
               check_value("trough_z", {32'd0, want.trough[2]}, {32'd0, rsp_trough_z});
            end
         end
         if (req_valid && !req_stall) begin
            case (req_op)
               OP_SAMPLE: begin
                  if (int'(req_quantity) < PCET_QUANTITIES) begin
                     ax[0] = req_axis_x;
                     ax[1] = req_axis_y;
                     ax[2] = req_axis_z;
                     slot = int'(req_quantity);
                     extremum_store[slot] =
                        raise_entry(extremum_store[slot], req_magnitude_squared, ax);
                     if (int'(req_particle_class) < PCET_MAX_CLASSES) begin
                        slot = (int'(req_particle_class) + 1) * PCET_QUANTITIES
                               + int'(req_quantity);
                        extremum_store[slot] =
                           raise_entry(extremum_store[slot], req_magnitude_squared, ax);
                     end
                  end
               end
               OP_READ: begin
                  want = '0;
                  if (int'(req_quantity) < PCET_QUANTITIES
                      && int'(req_read_row) <= PCET_MAX_CLASSES) begin
                     slot = int'(req_read_row) * PCET_QUANTITIES + int'(req_quantity);
                     want = extremum_store[slot];
                  end
                  expected_rows.push_back(want);
               end
               OP_CLEAR: clear_store();
               default: ;
            endcase
         end
      end
      outstanding <= expected_rows.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives samples, reads, clears and unused codes into the extremum tracker
// with random gaps and receiver stalls, a long receiver hold-off and drained
// pauses; the checker beside the block predicts and compares every read word
// ----------------------------------------------------------------------------
module tb;
   import pcet_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int ITEM_TARGET    = 1300;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 3000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_op;
   logic [4:0]         req_particle_class;
   logic [1:0]         req_quantity;
   logic [62:0]        req_magnitude_squared;
   logic signed [31:0] req_axis_x;
   logic signed [31:0] req_axis_y;
   logic signed [31:0] req_axis_z;
   logic [4:0]         req_read_row;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [62:0]        rsp_peak_magnitude_squared;
   logic [30:0]        rsp_peak_x;
   logic [30:0]        rsp_peak_y;
   logic [30:0]        rsp_peak_z;
   logic signed [31:0] rsp_trough_x;
   logic signed [31:0] rsp_trough_y;
   logic signed [31:0] rsp_trough_z;

   int error_count;
   int outstanding;
   int tx_gap_max;
   int rx_gap_max;
   bit rx_hold_request;

   per_class_extremum_tracker_unit u_dut (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_stall                  (req_stall),
      .req_op                     (req_op),
      .req_particle_class         (req_particle_class),
      .req_quantity               (req_quantity),
      .req_magnitude_squared      (req_magnitude_squared),
      .req_axis_x                 (req_axis_x),
      .req_axis_y                 (req_axis_y),
      .req_axis_z                 (req_axis_z),
      .req_read_row               (req_read_row),
      .rsp_valid                  (rsp_valid),
      .rsp_stall                  (rsp_stall),
      .rsp_peak_magnitude_squared (rsp_peak_magnitude_squared),
      .rsp_peak_x                 (rsp_peak_x),
      .rsp_peak_y                 (rsp_peak_y),
      .rsp_peak_z                 (rsp_peak_z),
      .rsp_trough_x               (rsp_trough_x),
      .rsp_trough_y               (rsp_trough_y),
      .rsp_trough_z               (rsp_trough_z)
   );

   extremum_checker u_checker (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_stall                  (req_stall),
      .req_op                     (req_op),
      .req_particle_class         (req_particle_class),
      .req_quantity               (req_quantity),
      .req_magnitude_squared      (req_magnitude_squared),
      .req_axis_x                 (req_axis_x),
      .req_axis_y                 (req_axis_y),
      .req_axis_z                 (req_axis_z),
      .req_read_row               (req_read_row),
      .rsp_valid                  (rsp_valid),
      .rsp_stall                  (rsp_stall),
      .rsp_peak_magnitude_squared (rsp_peak_magnitude_squared),
      .rsp_peak_x                 (rsp_peak_x),
      .rsp_peak_y                 (rsp_peak_y),
      .rsp_peak_z                 (rsp_peak_z),
      .rsp_trough_x               (rsp_trough_x),
      .rsp_trough_y               (rsp_trough_y),
      .rsp_trough_z               (rsp_trough_z),
      .error_count                (error_count),
      .outstanding                (outstanding)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic int pick_gap_max();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 3;
         default: return 15;
      endcase
   endfunction

   function automatic logic [62:0] random_magnitude();
      logic [63:0] w;
      w = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 0) w = 64'($urandom_range(0, 100000));
      return w[62:0];
   endfunction

   function automatic logic [31:0] random_axis();
      case ($urandom_range(0, 3))
         0: return 32'($urandom_range(0, 2000)) - 32'd1000;
         1: begin
            case ($urandom_range(0, 3))
               0:       return 32'h7fffffff;
               1:       return 32'h80000000;
               2:       return 32'hffffffff;
               default: return 32'h00000000;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(input logic [1:0] op, input logic [4:0] cls,
                            input logic [1:0] q, input logic [62:0] mag,
                            input logic [31:0] ax, input logic [31:0] ay,
                            input logic [31:0] az, input logic [4:0] row);
      int gap;
      gap = $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_op                <= op;
      req_particle_class    <= cls;
      req_quantity          <= q;
      req_magnitude_squared <= mag;
      req_axis_x            <= ax;
      req_axis_y            <= ay;
      req_axis_z            <= az;
      req_read_row          <= row;
      req_valid             <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic random_word(input logic [1:0] op);
      send_word(op, 5'($urandom), 2'($urandom), random_magnitude(), random_axis(),
                random_axis(), random_axis(), 5'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // receiver side
   initial begin
      int gap;
      rsp_stall = 1'b0;
      forever begin
         if (rx_hold_request) begin
            rx_hold_request = 1'b0;
            gap = HOLDOFF_CYCLES;
         end else begin
            gap = $urandom_range(0, rx_gap_max);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("tb: errors");
      $finish;
   end

   initial begin
      int issued;
      int pick;
      int phase_items;
      req_valid             = 1'b0;
      req_op                = OP_SAMPLE;
      req_particle_class    = '0;
      req_quantity          = '0;
      req_magnitude_squared = '0;
      req_axis_x            = '0;
      req_axis_y            = '0;
      req_axis_z            = '0;
      req_read_row          = '0;
      reset                 = 1'b1;
      tx_gap_max            = 15;
      rx_gap_max            = 15;
      rx_hold_request       = 1'b0;
      issued                = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty store, extremes, out of range class, unused code, clear
      send_word(OP_READ, 5'd0, 2'd0, '0, '0, '0, '0, 5'd0);
      send_word(OP_SAMPLE, 5'd0, 2'd0, {63{1'b1}}, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff, 5'd31);
      send_word(OP_SAMPLE, 5'd30, 2'd1, '0, 32'h80000000, 32'h80000000,
                32'h80000000, 5'd0);
      send_word(OP_SAMPLE, 5'd31, 2'd2, 63'd1, 32'hffffffff, 32'h00000001,
                32'h00000000, 5'd31);
      send_word(OP_SAMPLE, 5'd5, 2'd3, random_magnitude(), random_axis(), random_axis(),
                random_axis(), 5'd6);
      send_word(OP_UNUSED, 5'd0, 2'd0, {63{1'b1}}, 32'h7fffffff, 32'h80000000,
                32'h7fffffff, 5'd0);
      send_word(OP_READ, 5'd0, 2'd0, '0, '0, '0, '0, 5'd0);
      send_word(OP_READ, 5'd0, 2'd1, '0, '0, '0, '0, 5'd0);
      send_word(OP_READ, 5'd0, 2'd2, '0, '0, '0, '0, 5'd0);
      send_word(OP_READ, 5'd0, 2'd3, '0, '0, '0, '0, 5'd0);
      send_word(OP_READ, 5'd0, 2'd0, '0, '0, '0, '0, 5'd1);
      send_word(OP_READ, 5'd0, 2'd1, '0, '0, '0, '0, 5'd31);
      send_word(OP_READ, 5'd0, 2'd2, '0, '0, '0, '0, 5'd31);
      send_word(OP_READ, 5'd0, 2'd3, '0, '0, '0, '0, 5'd6);
      send_word(OP_CLEAR, 5'd0, 2'd0, '0, '0, '0, '0, 5'd0);
      send_word(OP_READ, 5'd0, 2'd0, '0, '0, '0, '0, 5'd0);
      send_word(OP_READ, 5'd0, 2'd0, '0, '0, '0, '0, 5'd1);
      issued += 17;
      wait_drained();

      // receiver holds off while reads keep coming
      rx_hold_request = 1'b1;
      repeat (24) random_word(OP_READ);
      issued += 24;
      wait_drained();

      while (issued < ITEM_TARGET) begin
         tx_gap_max  = pick_gap_max();
         rx_gap_max  = pick_gap_max();
         phase_items = $urandom_range(80, 200);
         if (phase_items > ITEM_TARGET - issued) phase_items = ITEM_TARGET - issued;
         repeat (phase_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) random_word(OP_SAMPLE);
            else if (pick < 90) random_word(OP_READ);
            else if (pick < 92) random_word(OP_CLEAR);
            else random_word(OP_UNUSED);
            issued++;
         end
         wait_drained();
      end

      repeat (16) @(posedge clock);
      if (error_count == 0 && outstanding == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

endmodule
